// ===== design/mrfr_pkg.sv =====
package mrfr_pkg;

  localparam int unsigned TIMER_W          = 16;
  localparam int unsigned ADDR_W           = 8;
  localparam int unsigned FRAME_LEN_W      = 9;
  localparam int unsigned BYTE_W           = 8;
  localparam int unsigned CRC_W            = 16;
  localparam int unsigned CFG_IDX_W        = 3;
  localparam int unsigned CFG_DATA_W       = 16;
  localparam int unsigned BUFFER_BYTES_DEF = 256;

  localparam logic [TIMER_W-1:0]     TIMER_MAX       = '1;
  localparam logic [CRC_W-1:0]       CRC_INIT        = 16'hFFFF;
  localparam logic [CRC_W-1:0]       CRC_POLY        = 16'hA001;
  localparam logic [TIMER_W-1:0]     SILENCE_DEF     = 16'd35;
  localparam logic [TIMER_W-1:0]     GAP_DEF         = 16'd15;
  localparam logic [ADDR_W-1:0]      OWN_ADDR_DEF    = 8'd1;
  localparam logic [FRAME_LEN_W-1:0] MIN_LENGTH_DEF  = 9'd4;
  localparam logic [ADDR_W-1:0]      BROADCAST_ADDR  = 8'd0;

  typedef enum logic [2:0] {
    KIND_DATA  = 3'd0,
    KIND_GOOD  = 3'd1,
    KIND_ADDR  = 3'd2,
    KIND_SHORT = 3'd3,
    KIND_CRC   = 3'd4,
    KIND_GAP   = 3'd5,
    KIND_OVER  = 3'd6
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SILENCE    = 3'd0,
    CFG_GAP        = 3'd1,
    CFG_OWN_ADDR   = 3'd2,
    CFG_MIN_LENGTH = 3'd3
  } cfg_idx_e;

  typedef struct packed {
    logic              mode;
    logic [BYTE_W-1:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    kind_e                  kind;
    logic [BYTE_W-1:0]      data_byte;
    logic [BYTE_W-1:0]      byte_index;
    logic [FRAME_LEN_W-1:0] frame_length;
    logic                   is_broadcast;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_req_t;

  typedef struct packed {
    logic start;
    logic update;
  } crc_ctrl_t;

  function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== design/mrfr_chan_if.sv =====
interface mrfr_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== design/modbus_rtu_frame_receiver.sv =====
// Modbus RTU receive framer. Each request on in_i is a timer tick (mode 0) or a received
// UART byte (mode 1); frame bytes stream out on out_o as data results, and each frame
// closes with one verdict (good, wrong address, too short, bad CRC) once t3.5 of silence
// has passed, or earlier with a gap abort. A full buffer drops further bytes with an
// overflow result. One request is taken every clock cycle: it is registered, then resolved
// against the framing state and the CRC-16 register, and its result lands in an output
// register; the rate drops only while out_o is stalled. Configuration writes take effect
// at once and are expected only while the block is idle.
module modbus_rtu_frame_receiver
  import mrfr_pkg::*;
#(
  parameter int unsigned BufferBytes = BUFFER_BYTES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  mrfr_chan_if.sink     cfg_i,
  mrfr_chan_if.sink     in_i,
  mrfr_chan_if.source   out_o
);

  localparam int unsigned CntW = $clog2(BufferBytes + 1);

  logic [TIMER_W-1:0]     silence_ticks_q;
  logic [TIMER_W-1:0]     gap_ticks_q;
  logic [ADDR_W-1:0]      own_address_q;
  logic [FRAME_LEN_W-1:0] min_length_q;

  logic                   s1_valid_q;
  in_item_t               s1_q;

  logic [TIMER_W-1:0]     timer_q, timer_d;
  logic                   receiving_q, receiving_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [ADDR_W-1:0]      first_byte_q, first_byte_d;

  logic                   out_valid_q, out_valid_d;
  out_item_t              out_q, out_d;

  logic                   advance;
  logic                   in_ready;
  crc_ctrl_t              crc_ctrl;
  logic [CRC_W-1:0]       crc;
  logic [FRAME_LEN_W-1:0] count_len;
  logic                   bcast;

  assign advance   = !out_valid_q || out_o.ready;
  assign in_ready  = !s1_valid_q || advance;
  assign count_len = FRAME_LEN_W'(count_q);
  assign bcast     = (first_byte_q == BROADCAST_ADDR);

  assign cfg_i.ready   = 1'b1;
  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      silence_ticks_q <= SILENCE_DEF;
      gap_ticks_q     <= GAP_DEF;
      own_address_q   <= OWN_ADDR_DEF;
      min_length_q    <= MIN_LENGTH_DEF;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.payload.index)
        CFG_SILENCE:    silence_ticks_q <= cfg_i.payload.data[TIMER_W-1:0];
        CFG_GAP:        gap_ticks_q     <= cfg_i.payload.data[TIMER_W-1:0];
        CFG_OWN_ADDR:   own_address_q   <= cfg_i.payload.data[ADDR_W-1:0];
        CFG_MIN_LENGTH: min_length_q    <= cfg_i.payload.data[FRAME_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      s1_q <= in_i.payload;
    end
  end

  always_comb begin
    timer_d      = timer_q;
    receiving_d  = receiving_q;
    count_d      = count_q;
    first_byte_d = first_byte_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_d        = out_q;
    crc_ctrl     = '0;

    if (s1_valid_q && advance) begin
      out_d = '{kind: KIND_DATA, data_byte: '0, byte_index: '0,
                frame_length: count_len, is_broadcast: bcast};
      if (!s1_q.mode) begin
        if (timer_q <= silence_ticks_q && timer_q != TIMER_MAX) begin
          timer_d = timer_q + TIMER_W'(1);
        end else if (receiving_q) begin
          receiving_d = 1'b0;
          count_d     = '0;
          out_valid_d = 1'b1;
          if (first_byte_q != own_address_q && !bcast) begin
            out_d.kind = KIND_ADDR;
          end else if (count_len < min_length_q) begin
            out_d.kind = KIND_SHORT;
          end else if (crc != '0) begin
            out_d.kind = KIND_CRC;
          end else begin
            out_d.kind = KIND_GOOD;
          end
        end
      end else if (receiving_q) begin
        out_valid_d = 1'b1;
        if (timer_q >= gap_ticks_q) begin
          out_d.kind  = KIND_GAP;
          count_d     = '0;
          receiving_d = 1'b0;
          timer_d     = '0;
        end else if (count_q < CntW'(BufferBytes)) begin
          out_d = '{kind: KIND_DATA, data_byte: s1_q.rx_byte,
                    byte_index: BYTE_W'(count_q), frame_length: '0, is_broadcast: 1'b0};
          count_d         = count_q + CntW'(1);
          crc_ctrl.update = 1'b1;
          timer_d         = '0;
        end else begin
          out_d.kind = KIND_OVER;
        end
      end else if (timer_q >= silence_ticks_q) begin
        receiving_d    = 1'b1;
        first_byte_d   = s1_q.rx_byte;
        count_d        = CntW'(1);
        crc_ctrl.start = 1'b1;
        timer_d        = '0;
        out_valid_d    = 1'b1;
        out_d = '{kind: KIND_DATA, data_byte: s1_q.rx_byte, byte_index: '0,
                  frame_length: '0, is_broadcast: 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_q      <= '0;
      receiving_q  <= 1'b0;
      count_q      <= '0;
      first_byte_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      timer_q      <= timer_d;
      receiving_q  <= receiving_d;
      count_q      <= count_d;
      first_byte_q <= first_byte_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  mrfr_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (crc_ctrl),
    .data_i (s1_q.rx_byte),
    .crc_o  (crc)
  );

  a_open_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    receiving_q == (count_q != '0))
    else $error("frame open flag and byte count disagree");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(BufferBytes))
    else $error("byte count beyond buffer size");

  a_data_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind == KIND_DATA |-> receiving_q)
    else $error("data result without an open frame");

  a_gap_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind == KIND_GAP |-> !receiving_q && timer_q == '0)
    else $error("gap abort left frame state behind");

  a_crc_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(crc_ctrl.start && crc_ctrl.update))
    else $error("crc start and update together");

endmodule

// ===== design/mrfr_crc.sv =====
module mrfr_crc
  import mrfr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  crc_ctrl_t         ctrl_i,
  input  logic [BYTE_W-1:0] data_i,
  output logic [CRC_W-1:0]  crc_o
);

  logic [CRC_W-1:0] crc_q;
  logic [CRC_W-1:0] crc_d;

  always_comb begin
    crc_d = crc_q;
    if (ctrl_i.start) begin
      crc_d = crc16_byte(CRC_INIT, data_i);
    end else if (ctrl_i.update) begin
      crc_d = crc16_byte(crc_q, data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CRC_INIT;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

// ===== tb/sv/tb_modbus_rtu_frame_receiver.sv =====
`timescale 1ns / 1ps

module tb_modbus_rtu_frame_receiver;
  import mrfr_pkg::*;

  class frame_scoreboard;
    logic [TIMER_W-1:0]     silence_ticks;
    logic [TIMER_W-1:0]     gap_ticks;
    logic [ADDR_W-1:0]      own_addr;
    logic [FRAME_LEN_W-1:0] min_len;
    logic [TIMER_W-1:0]     quiet_count;
    bit                     in_frame;
    logic [FRAME_LEN_W-1:0] byte_count;
    logic [ADDR_W-1:0]      first_byte;
    logic [CRC_W-1:0]       crc;
    out_item_t              expected_q[$];
    int                     errors;

    function new();
      silence_ticks = SILENCE_DEF;
      gap_ticks     = GAP_DEF;
      own_addr      = OWN_ADDR_DEF;
      min_len       = MIN_LENGTH_DEF;
      quiet_count   = '0;
      in_frame      = 1'b0;
      byte_count    = '0;
      first_byte    = '0;
      crc           = CRC_INIT;
      errors        = 0;
    endfunction

    static function logic [CRC_W-1:0] crc_next(logic [CRC_W-1:0] c, logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] r;
      r = c ^ {8'h00, b};
      repeat (BYTE_W) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      return r;
    endfunction

    function void write_reg(cfg_req_t w);
      case (cfg_idx_e'(w.index))
        CFG_SILENCE:    silence_ticks = w.data;
        CFG_GAP:        gap_ticks = w.data;
        CFG_OWN_ADDR:   own_addr = w.data[ADDR_W-1:0];
        CFG_MIN_LENGTH: min_len = w.data[FRAME_LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function void push_verdict(kind_e k);
      out_item_t e;
      e.kind         = k;
      e.data_byte    = '0;
      e.byte_index   = '0;
      e.frame_length = byte_count;
      e.is_broadcast = (first_byte == BROADCAST_ADDR);
      expected_q.push_back(e);
    endfunction

    function void push_data(logic [BYTE_W-1:0] b);
      out_item_t e;
      e.kind         = KIND_DATA;
      e.data_byte    = b;
      e.byte_index   = byte_count[BYTE_W-1:0];
      e.frame_length = '0;
      e.is_broadcast = 1'b0;
      expected_q.push_back(e);
    endfunction

    function void note_request(in_item_t req);
      if (!req.mode) begin
        if (quiet_count <= silence_ticks && quiet_count != TIMER_MAX) begin
          quiet_count++;
        end else if (in_frame) begin
          in_frame = 1'b0;
          if (first_byte != own_addr && first_byte != BROADCAST_ADDR) push_verdict(KIND_ADDR);
          else if (byte_count < min_len) push_verdict(KIND_SHORT);
          else if (crc != '0) push_verdict(KIND_CRC);
          else push_verdict(KIND_GOOD);
          byte_count = '0;
        end
      end else if (in_frame) begin
        if (quiet_count >= gap_ticks) begin
          push_verdict(KIND_GAP);
          byte_count  = '0;
          in_frame    = 1'b0;
          quiet_count = '0;
        end else if (byte_count < BUFFER_BYTES_DEF) begin
          push_data(req.rx_byte);
          byte_count++;
          crc         = crc_next(crc, req.rx_byte);
          quiet_count = '0;
        end else begin
          push_verdict(KIND_OVER);
        end
      end else if (quiet_count >= silence_ticks) begin
        in_frame    = 1'b1;
        first_byte  = req.rx_byte;
        byte_count  = '0;
        push_data(req.rx_byte);
        byte_count  = FRAME_LEN_W'(1);
        crc         = crc_next(CRC_INIT, req.rx_byte);
        quiet_count = '0;
      end
    endfunction

    function void compare_field(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
        $display("%0t: %s expected %0d, got %0d", $time, name, exp, act);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result kind %0d with nothing expected", $time, got.kind);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      compare_field("kind", e.kind, got.kind);
      compare_field("data_byte", e.data_byte, got.data_byte);
      compare_field("byte_index", e.byte_index, got.byte_index);
      compare_field("frame_length", e.frame_length, got.frame_length);
      compare_field("is_broadcast", e.is_broadcast, got.is_broadcast);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mrfr_chan_if #(.payload_t(cfg_req_t))  cfg_if ();
  mrfr_chan_if #(.payload_t(in_item_t))  in_if ();
  mrfr_chan_if #(.payload_t(out_item_t)) out_if ();

  modbus_rtu_frame_receiver DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  frame_scoreboard sb = new();
  int bytes_sent;
  bit sender_burst;
  bit rx_burst;
  bit hold_off_req;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic send_item(logic mode, logic [BYTE_W-1:0] b);
    in_item_t req;
    int idle;
    idle = sender_burst ? 0 : $urandom_range(0, 6);
    req.mode    = mode;
    req.rx_byte = b;
    if (idle > 0) begin
      in_if.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= req;
    do @(posedge clk); while (!in_if.ready);
    sb.note_request(req);
    if (mode) bytes_sent++;
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_item(1'b0, BYTE_W'($urandom_range(0, 255)));
  endtask

  task automatic send_frame(logic [BYTE_W-1:0] f[$]);
    foreach (f[i]) send_item(1'b1, f[i]);
  endtask

  function automatic void add_crc(ref logic [BYTE_W-1:0] f[$]);
    logic [CRC_W-1:0] c;
    c = CRC_INIT;
    foreach (f[i]) c = frame_scoreboard::crc_next(c, f[i]);
    f.push_back(c[7:0]);
    f.push_back(c[15:8]);
  endfunction

  task automatic set_config(logic [15:0] sil, logic [15:0] gap, logic [15:0] addr,
                            logic [15:0] min_bytes);
    cfg_idx_e    regs[4];
    logic [15:0] vals[4];
    cfg_req_t    w;
    regs = '{CFG_SILENCE, CFG_GAP, CFG_OWN_ADDR, CFG_MIN_LENGTH};
    vals = '{sil, gap, addr, min_bytes};
    cfg_if.valid <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      w.index = regs[i];
      w.data  = vals[i];
      cfg_if.payload <= w;
      do @(posedge clk); while (!cfg_if.ready);
      sb.write_reg(w);
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_frame(bit allow_long);
    logic [BYTE_W-1:0] f[$];
    int n;
    int lead;
    int cut;
    int gap_len;
    int inner_max;
    sender_burst = ($urandom_range(0, 3) == 0);
    lead = int'(sb.silence_ticks) + 1 + $urandom_range(0, 3);
    if ($urandom_range(0, 7) == 0) begin
      send_ticks($urandom_range(0, lead));
      send_item(1'b1, BYTE_W'($urandom_range(0, 255)));
    end
    send_ticks(lead);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: f.push_back(sb.own_addr);
      4, 5:       f.push_back(BROADCAST_ADDR);
      default:    f.push_back(BYTE_W'($urandom_range(0, 255)));
    endcase
    if (allow_long && $urandom_range(0, 11) == 0) n = $urandom_range(252, 260);
    else n = $urandom_range(0, 8);
    repeat (n) f.push_back(BYTE_W'($urandom_range(0, 255)));
    if ($urandom_range(0, 7) != 0) add_crc(f);
    if ($urandom_range(0, 5) == 0)
      f[$urandom_range(0, f.size() - 1)] ^= 8'h01 << $urandom_range(0, 7);
    cut = (f.size() > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(1, f.size() - 1) : -1;
    gap_len = (sb.gap_ticks <= sb.silence_ticks) ? int'(sb.gap_ticks) + $urandom_range(0, 2)
                                                 : int'(sb.silence_ticks) + 2;
    inner_max = (sb.gap_ticks > 5) ? 3 : int'(sb.gap_ticks) - 2;
    foreach (f[i]) begin
      if (i == cut) send_ticks(gap_len);
      else if (i > 0 && inner_max >= 0 && $urandom_range(0, 5) == 0)
        send_ticks($urandom_range(0, inner_max));
      send_item(1'b1, f[i]);
    end
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 3))
        send_item(1'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)));
  endtask

  task automatic run_phase(logic [15:0] sil, logic [15:0] gap, logic [15:0] addr,
                           logic [15:0] min_bytes, int budget, bit allow_long, bit squeeze);
    set_config(sil, gap, addr, min_bytes);
    bytes_sent = 0;
    if (squeeze) hold_off_req = 1'b1;
    while (bytes_sent < budget) random_frame(allow_long);
    send_ticks(int'(sb.silence_ticks) + 2);
    drain();
  endtask

  initial begin
    int idle;
    int taken;
    taken = 0;
    out_if.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        idle = rx_burst ? 0 : $urandom_range(0, 6);
        if (idle > 0) begin
          out_if.ready <= 1'b0;
          repeat (idle) @(posedge clk);
        end
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      sb.check_result(out_if.payload);
      taken++;
      if (taken % 40 == 0) rx_burst = ($urandom_range(0, 2) == 0);
    end
  end

  initial begin
    logic [BYTE_W-1:0] f[$];
    cfg_if.valid   <= 1'b0;
    cfg_if.payload <= '0;
    in_if.valid    <= 1'b0;
    in_if.payload  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // byte before any silence is ignored
    send_item(1'b1, 8'hAA);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h00);
    send_ticks(36);
    f = '{8'h01, 8'h03};
    add_crc(f);
    send_frame(f);
    send_ticks(37);
    f = '{8'h00, 8'hFF};
    add_crc(f);
    send_frame(f);
    send_ticks(37);
    f = '{8'hFF};
    add_crc(f);
    send_frame(f);
    send_ticks(37);
    f = '{8'h01, 8'h00};
    send_frame(f);
    send_ticks(37);
    f = '{8'h01, 8'h06, 8'h00, 8'h01, 8'h12, 8'h34};
    send_frame(f);
    send_ticks(37);
    // long gap aborts, then the restarted timer drops the next byte
    send_item(1'b1, 8'h01);
    send_ticks(15);
    send_item(1'b1, 8'h02);
    send_item(1'b1, 8'h80);
    send_ticks(37);
    drain();

    run_phase(16'd6, 16'd3, 16'h11, 16'd1, 80, 1'b0, 1'b1);
    run_phase(16'd0, 16'd0, 16'h00, 16'd256, 50, 1'b0, 1'b0);
    run_phase(16'd12, 16'd65534, 16'hFF, 16'd256, 120, 1'b1, 1'b0);
    run_phase(16'd9, 16'd4, 16'h5A, 16'd4, 90, 1'b1, 1'b0);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
